[rtl/lru_victim_select_prefer_clean_defines.svh]
// Assertion macros shared by the RTL files.
`ifndef LRU_VICTIM_SELECT_PREFER_CLEAN_DEFINES_SVH
`define LRU_VICTIM_SELECT_PREFER_CLEAN_DEFINES_SVH
`ifndef SYNTH
`define LVS_ASSERT_IMP(name, clk_s, rst_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("lvs assertion failed");
`define LVS_ASSERT_NXT(name, clk_s, rst_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("lvs assertion failed");
`else
`define LVS_ASSERT_IMP(name, clk_s, rst_s, ante, cons)
`define LVS_ASSERT_NXT(name, clk_s, rst_s, ante, cons)
`endif
`endif

[rtl/lvs_pkg.sv]
`timescale 1ns / 1ps
package lvs_pkg;

  localparam int NUM_SETS_DEF = 64;
  localparam int NUM_WAYS_DEF = 8;
  localparam int TAG_W        = 32;
  localparam int STAMP_W      = 32;
  localparam int WAYIDX_W     = 5;

  localparam logic [STAMP_W-1:0] STAMP_RELEASED = 32'h7FFF_FFFF;

  typedef enum logic [1:0] {
    FUNC_ACCESS = 2'd0,
    FUNC_EVICT  = 2'd1,
    FUNC_UPDATE = 2'd2
  } func_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic                valid;
    logic [WAYIDX_W-1:0] way;
    logic                active;
    logic                dirty;
    logic [STAMP_W-1:0]  stamp;
  } scan_t;

  typedef struct packed {
    logic                found;
    logic [WAYIDX_W-1:0] way;
  } pick_t;

endpackage

[rtl/lvs_ifs.sv]
`timescale 1ns / 1ps
interface lvs_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [5:0]  set_index;
  logic [31:0] tag;
  logic [2:0]  way;
  logic        dirty;

  modport source (output valid, output func, output set_index, output tag, output way,
                  output dirty, input ready);
  modport sink (input valid, input func, input set_index, input tag, input way,
                input dirty, output ready);
endinterface

interface lvs_rsp_if;
  logic       valid;
  logic       ready;
  logic [2:0] victim_way;
  logic       hit;
  logic       none_found;

  modport source (output valid, output victim_way, output hit, output none_found,
                  input ready);
  modport sink (input valid, input victim_way, input hit, input none_found,
                output ready);
endinterface

interface lvs_cfg_if;
  logic valid;
  logic ready;
  logic policy_mode;

  modport source (output valid, output policy_mode, input ready);
  modport sink (input valid, input policy_mode, output ready);
endinterface

[rtl/lru_victim_select_prefer_clean.sv]
`timescale 1ns / 1ps
`include "lru_victim_select_prefer_clean_defines.svh"
// Access and eviction: one way read per cycle from the line memories through the scan,
// then the drain and finish states; the result is registered once the output is free and
// no new item is accepted before then. Line update, unused codes and out-of-range sets go
// straight to finish. The single read port of the line memories sets the scan length.
// After reset a clearing pass over all NUM_SETS * NUM_WAYS lines (512 by default) zeroes the
// memories; no item is accepted until it ends. Configuration writes are taken at any time.
module lru_victim_select_prefer_clean #(
  parameter int NUM_SETS = lvs_pkg::NUM_SETS_DEF,
  parameter int NUM_WAYS = lvs_pkg::NUM_WAYS_DEF
) (
  input logic       clk,
  input logic       rst,
  lvs_req_if.sink   req,
  lvs_rsp_if.source rsp,
  lvs_cfg_if.sink   cfg
);

  localparam int DEPTH  = NUM_SETS * NUM_WAYS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int WAY_W  = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
  localparam int WORD_W = lvs_pkg::TAG_W + 1;

  lvs_pkg::state_t state, state_next;

  logic                        policy;
  logic [lvs_pkg::TAG_W-1:0]   access_clock;
  logic [ADDR_W-1:0]           clr_addr;

  logic [1:0]                  req_func;
  logic                        req_set_ok;
  logic                        req_way_ok;
  logic [ADDR_W-1:0]           req_base;
  logic [lvs_pkg::TAG_W-1:0]   req_tag;
  logic [2:0]                  req_way;
  logic                        req_dirty;

  logic [WAY_W-1:0]            rd_way;
  logic                        chk_valid;
  logic [WAY_W-1:0]            chk_way;
  logic                        found;
  logic [WAY_W-1:0]            found_way;

  logic                        rsp_valid;
  logic [2:0]                  rsp_victim;
  logic                        rsp_hit;
  logic                        rsp_none;

  logic                        req_ready;
  logic                        accept;
  logic                        fin_go;
  logic                        clock_inc;
  logic [2:0]                  fin_victim;
  logic                        fin_hit;
  logic                        fin_none;

  // Tag memory holds {dirty, tag}; stamp memory holds {active, stamp}.
  logic [WORD_W-1:0]           tag_mem   [DEPTH];
  logic [WORD_W-1:0]           stamp_mem [DEPTH];
  logic [WORD_W-1:0]           tag_q;
  logic [WORD_W-1:0]           stamp_q;
  logic [ADDR_W-1:0]           rd_addr;
  logic                        tag_we;
  logic [ADDR_W-1:0]           tag_waddr;
  logic [WORD_W-1:0]           tag_wdata;
  logic                        st_we;
  logic [ADDR_W-1:0]           st_waddr;
  logic [WORD_W-1:0]           st_wdata;

  lvs_pkg::scan_t              step;
  lvs_pkg::pick_t              pick;

  assign req_ready = (state == lvs_pkg::S_IDLE);
  assign req.ready = req_ready;
  assign accept    = req.valid && req_ready;
  assign cfg.ready = 1'b1;

  assign rsp.valid      = rsp_valid;
  assign rsp.victim_way = rsp_victim;
  assign rsp.hit        = rsp_hit;
  assign rsp.none_found = rsp_none;

  assign rd_addr = req_base + ADDR_W'(rd_way);
  assign fin_go  = (state == lvs_pkg::S_FINISH) && (!rsp_valid || rsp.ready);

  always_ff @(posedge clk) begin
    if (tag_we) begin
      tag_mem[tag_waddr] <= tag_wdata;
    end
    if (st_we) begin
      stamp_mem[st_waddr] <= st_wdata;
    end
    tag_q   <= tag_mem[rd_addr];
    stamp_q <= stamp_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lvs_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    tag_we     = 1'b0;
    tag_waddr  = req_base + ADDR_W'(req_way);
    tag_wdata  = {req_dirty, req_tag};
    st_we      = 1'b0;
    st_waddr   = req_base + ADDR_W'(found_way);
    st_wdata   = {1'b1, access_clock + 32'd1};
    clock_inc  = 1'b0;
    fin_victim = 3'd0;
    fin_hit    = 1'b0;
    fin_none   = 1'b0;
    case (req_func)
      lvs_pkg::FUNC_ACCESS: begin
        fin_hit = found;
      end
      lvs_pkg::FUNC_EVICT: begin
        fin_victim = pick.found ? pick.way[2:0] : 3'd0;
        fin_none   = !pick.found;
      end
      default: begin
      end
    endcase
    case (state)
      lvs_pkg::S_CLEAR: begin
        tag_we    = 1'b1;
        tag_waddr = clr_addr;
        tag_wdata = '0;
        st_we     = 1'b1;
        st_waddr  = clr_addr;
        st_wdata  = '0;
        if (clr_addr == ADDR_W'(DEPTH - 1)) begin
          state_next = lvs_pkg::S_IDLE;
        end
      end
      lvs_pkg::S_IDLE: begin
        if (accept) begin
          if (int'(req.set_index) < NUM_SETS &&
              (req.func == lvs_pkg::FUNC_ACCESS || req.func == lvs_pkg::FUNC_EVICT)) begin
            state_next = lvs_pkg::S_SCAN;
          end else begin
            state_next = lvs_pkg::S_FINISH;
          end
        end
      end
      lvs_pkg::S_SCAN: begin
        if (rd_way == WAY_W'(NUM_WAYS - 1)) begin
          state_next = lvs_pkg::S_DRAIN;
        end
      end
      lvs_pkg::S_DRAIN: begin
        state_next = lvs_pkg::S_FINISH;
      end
      lvs_pkg::S_FINISH: begin
        if (fin_go) begin
          state_next = lvs_pkg::S_IDLE;
          case (req_func)
            lvs_pkg::FUNC_ACCESS: begin
              st_we     = found;
              clock_inc = found;
            end
            lvs_pkg::FUNC_EVICT: begin
              st_we    = pick.found;
              st_waddr = req_base + ADDR_W'(pick.way);
              st_wdata = {1'b0, lvs_pkg::STAMP_RELEASED};
            end
            lvs_pkg::FUNC_UPDATE: begin
              tag_we = req_set_ok && req_way_ok;
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
        state_next = lvs_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr     <= '0;
      access_clock <= '0;
      policy       <= 1'b0;
      chk_valid    <= 1'b0;
      found        <= 1'b0;
      rsp_valid    <= 1'b0;
    end else begin
      if (state == lvs_pkg::S_CLEAR) begin
        clr_addr <= clr_addr + ADDR_W'(1);
      end
      if (cfg.valid) begin
        policy <= cfg.policy_mode;
      end
      if (clock_inc) begin
        access_clock <= access_clock + 32'd1;
      end
      chk_valid <= (state == lvs_pkg::S_SCAN);
      if (accept) begin
        found <= 1'b0;
      end else if (chk_valid && req_func == lvs_pkg::FUNC_ACCESS &&
                   tag_q[lvs_pkg::TAG_W-1:0] == req_tag) begin
        // Later ways overwrite, so the highest matching way wins.
        found <= 1'b1;
      end
      if (fin_go) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    chk_way <= rd_way;
    if (accept) begin
      req_func   <= req.func;
      req_set_ok <= int'(req.set_index) < NUM_SETS;
      req_way_ok <= int'(req.way) < NUM_WAYS;
      req_base   <= (int'(req.set_index) < NUM_SETS) ?
                    ADDR_W'(int'(req.set_index) * NUM_WAYS) : '0;
      req_tag    <= req.tag;
      req_way    <= req.way;
      req_dirty  <= req.dirty;
      rd_way     <= '0;
    end else if (state == lvs_pkg::S_SCAN) begin
      rd_way <= rd_way + WAY_W'(1);
    end
    if (chk_valid && req_func == lvs_pkg::FUNC_ACCESS &&
        tag_q[lvs_pkg::TAG_W-1:0] == req_tag) begin
      found_way <= chk_way;
    end
    if (fin_go) begin
      rsp_victim <= fin_victim;
      rsp_hit    <= fin_hit;
      rsp_none   <= fin_none;
    end
  end

  assign step.valid  = chk_valid && (req_func == lvs_pkg::FUNC_EVICT);
  assign step.way    = lvs_pkg::WAYIDX_W'(chk_way);
  assign step.active = stamp_q[lvs_pkg::STAMP_W];
  assign step.dirty  = tag_q[lvs_pkg::TAG_W];
  assign step.stamp  = stamp_q[lvs_pkg::STAMP_W-1:0];

  lvs_victim_pick u_pick (
    .clk    (clk),
    .rst    (rst),
    .clear  (accept),
    .policy (policy),
    .step   (step),
    .pick   (pick)
  );

  `LVS_ASSERT_IMP(a_hit_excl, clk, rst, rsp_valid && rsp_hit, rsp_victim == 3'd0 && !rsp_none)
  `LVS_ASSERT_IMP(a_none_zero, clk, rst, rsp_valid && rsp_none, rsp_victim == 3'd0 && !rsp_hit)
  `LVS_ASSERT_NXT(a_clock_hold, clk, rst, !clock_inc, $stable(access_clock))
  `LVS_ASSERT_IMP(a_chk_scan, clk, rst, chk_valid, state == lvs_pkg::S_SCAN || state == lvs_pkg::S_DRAIN)

endmodule

[rtl/lvs_victim_pick.sv]
`timescale 1ns / 1ps
`include "lru_victim_select_prefer_clean_defines.svh"
module lvs_victim_pick (
  input  logic           clk,
  input  logic           rst,
  input  logic           clear,
  input  logic           policy,
  input  lvs_pkg::scan_t step,
  output lvs_pkg::pick_t pick
);

  logic                         clean_v;
  logic [lvs_pkg::WAYIDX_W-1:0] clean_way;
  logic [lvs_pkg::STAMP_W-1:0]  clean_stamp;
  logic                         dirty_v;
  logic [lvs_pkg::WAYIDX_W-1:0] dirty_way;
  logic [lvs_pkg::STAMP_W-1:0]  dirty_stamp;
  logic                         clean_older;

  // Ways arrive in ascending order, so a strict compare keeps the lowest way on a tie.
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      clean_v <= 1'b0;
      dirty_v <= 1'b0;
    end else if (step.valid && step.active) begin
      if (step.dirty) begin
        if (!dirty_v || step.stamp < dirty_stamp) begin
          dirty_v     <= 1'b1;
          dirty_way   <= step.way;
          dirty_stamp <= step.stamp;
        end
      end else begin
        if (!clean_v || step.stamp < clean_stamp) begin
          clean_v     <= 1'b1;
          clean_way   <= step.way;
          clean_stamp <= step.stamp;
        end
      end
    end
  end

  always_comb begin
    clean_older = (clean_stamp < dirty_stamp) ||
                  ((clean_stamp == dirty_stamp) && (clean_way < dirty_way));
    if (clean_v && (policy || !dirty_v || clean_older)) begin
      pick.found = 1'b1;
      pick.way   = clean_way;
    end else if (dirty_v) begin
      pick.found = 1'b1;
      pick.way   = dirty_way;
    end else begin
      pick.found = 1'b0;
      pick.way   = '0;
    end
  end

  `LVS_ASSERT_NXT(a_clean_seen, clk, rst, step.valid && step.active && !step.dirty && !clear, clean_v)
  `LVS_ASSERT_NXT(a_dirty_seen, clk, rst, step.valid && step.active && step.dirty && !clear, dirty_v)
  `LVS_ASSERT_NXT(a_clear_empty, clk, rst, clear, !clean_v && !dirty_v)

endmodule

[dv/lru_victim_checker.sv]
`timescale 1ns / 1ps
module lru_victim_checker #(
  parameter int NUM_SETS = lvs_pkg::NUM_SETS_DEF,
  parameter int NUM_WAYS = lvs_pkg::NUM_WAYS_DEF
) (
  input  logic clk,
  input  logic rst,
  lvs_req_if   req,
  lvs_rsp_if   rsp,
  lvs_cfg_if   cfg,
  output int   fail_count,
  output int   pending
);

  typedef struct packed {
    logic [2:0] victim_way;
    logic       hit;
    logic       none_found;
  } lru_result_t;

  localparam int LINES = NUM_SETS * NUM_WAYS;

  logic [lvs_pkg::TAG_W-1:0]   way_tag   [LINES];
  logic                        way_dirty [LINES];
  logic                        way_live  [LINES];
  logic [lvs_pkg::STAMP_W-1:0] way_stamp [LINES];
  logic [lvs_pkg::STAMP_W-1:0] use_clock;
  logic                        clean_first;

  lru_result_t pending_results[$];
  lru_result_t want;
  int          errs;

  // Oldest live way of a set; with match_dirty, only ways whose dirty mark is want_dirty.
  function automatic int oldest_live(int base, bit match_dirty, logic want_dirty);
    int                          best = -1;
    logic [lvs_pkg::STAMP_W-1:0] best_stamp = '0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (way_live[base + w] && (!match_dirty || way_dirty[base + w] == want_dirty) &&
          (best < 0 || way_stamp[base + w] < best_stamp)) begin
        best       = w;
        best_stamp = way_stamp[base + w];
      end
    end
    return best;
  endfunction

  function automatic lru_result_t apply_request(logic [1:0] func, logic [5:0] set_index,
                                                logic [31:0] tag, logic [2:0] way,
                                                logic dirty);
    lru_result_t res = '0;
    bit          set_ok = int'(set_index) < NUM_SETS;
    int          base = set_ok ? int'(set_index) * NUM_WAYS : 0;
    int          found = -1;
    int          pick = -1;
    case (func)
      lvs_pkg::FUNC_ACCESS: begin
        if (set_ok) begin
          for (int w = 0; w < NUM_WAYS; w++)
            if (way_tag[base + w] == tag) found = w;
          if (found >= 0) begin
            use_clock             = use_clock + 32'd1;
            way_live[base + found]  = 1'b1;
            way_stamp[base + found] = use_clock;
            res.hit               = 1'b1;
          end
        end
      end
      lvs_pkg::FUNC_EVICT: begin
        if (set_ok) begin
          if (clean_first) begin
            pick = oldest_live(base, 1'b1, 1'b0);
            if (pick < 0) pick = oldest_live(base, 1'b1, 1'b1);
          end else begin
            pick = oldest_live(base, 1'b0, 1'b0);
          end
        end
        if (pick < 0) begin
          res.none_found = 1'b1;
        end else begin
          way_live[base + pick]  = 1'b0;
          way_stamp[base + pick] = lvs_pkg::STAMP_RELEASED;
          res.victim_way         = 3'(pick);
        end
      end
      lvs_pkg::FUNC_UPDATE: begin
        if (set_ok && int'(way) < NUM_WAYS) begin
          way_tag[base + way]   = tag;
          way_dirty[base + way] = dirty;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LINES; i++) begin
        way_tag[i]   = '0;
        way_dirty[i] = 1'b0;
        way_live[i]  = 1'b0;
        way_stamp[i] = '0;
      end
      use_clock   = '0;
      clean_first = 1'b0;
      errs        = 0;
      pending_results.delete();
    end else begin
      // compare first: a result never belongs to a request accepted on the same edge
      if (rsp.valid && rsp.ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result victim_way %0d hit %0d none_found %0d",
                   $time, rsp.victim_way, rsp.hit, rsp.none_found);
          errs++;
        end else begin
          want = pending_results.pop_front();
          if (rsp.victim_way !== want.victim_way) begin
            $display("%0t: victim_way expected %0d actual %0d",
                     $time, want.victim_way, rsp.victim_way);
            errs++;
          end
          if (rsp.hit !== want.hit) begin
            $display("%0t: hit expected %0d actual %0d", $time, want.hit, rsp.hit);
            errs++;
          end
          if (rsp.none_found !== want.none_found) begin
            $display("%0t: none_found expected %0d actual %0d",
                     $time, want.none_found, rsp.none_found);
            errs++;
          end
        end
      end
      if (cfg.valid && cfg.ready) clean_first = cfg.policy_mode;
      if (req.valid && req.ready)
        pending_results.push_back(apply_request(req.func, req.set_index, req.tag,
                                                req.way, req.dirty));
    end
    fail_count <= errs;
    pending    <= pending_results.size();
  end

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps
module tb;

  localparam logic [1:0] FUNC_SPARE    = 2'd3;
  localparam int         CYCLE_LIMIT   = 200000;
  localparam int         RANDOM_PHASES = 4;
  localparam int         PHASE_ITEMS   = 125;
  localparam int         LONG_HOLD     = 400;
  localparam int         HOLD_AFTER    = 90;

  logic        clk;
  logic        rst;
  int          fail_count;
  int          pending;
  int          rsp_count;
  int          cycle_count;
  int          burst_left;
  bit          long_hold_done;
  logic [31:0] tag_pool [8];

  lvs_req_if req_if ();
  lvs_rsp_if rsp_if ();
  lvs_cfg_if cfg_if ();

  lru_victim_select_prefer_clean u_top (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if),
    .cfg (cfg_if)
  );

  lru_victim_checker u_chk (
    .clk        (clk),
    .rst        (rst),
    .req        (req_if),
    .rsp        (rsp_if),
    .cfg        (cfg_if),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rsp_if.valid && rsp_if.ready) rsp_count <= rsp_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Result side: runs of full throughput, random stalls, full stalls, one long hold-off.
  initial begin : receiver
    int span;
    int pattern;
    rsp_if.ready = 1'b0;
    forever begin
      pattern = $urandom_range(0, 9);
      if (!long_hold_done && rsp_count >= HOLD_AFTER) begin
        // hold off so the block backs up and stalls its input
        long_hold_done = 1'b1;
        rsp_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        span = $urandom_range(5, 40);
        repeat (span) begin
          rsp_if.ready <= (pattern < 4)  ? 1'b1 :
                          (pattern >= 8) ? 1'b0 : ($urandom_range(0, 2) != 0);
          @(posedge clk);
        end
      end
    end
  end

  task automatic send_item(logic [1:0] func, logic [5:0] set_index, logic [31:0] tag,
                           logic [2:0] way, logic dirty);
    req_if.valid     <= 1'b1;
    req_if.func      <= func;
    req_if.set_index <= set_index;
    req_if.tag       <= tag;
    req_if.way       <= way;
    req_if.dirty     <= dirty;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 30);
      if ($urandom_range(0, 3) != 0) begin
        req_if.valid <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
    end
  endtask

  task automatic wait_for_results();
    req_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_policy(logic mode);
    wait_for_results();
    cfg_if.valid       <= 1'b1;
    cfg_if.policy_mode <= mode;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // Mostly requests on a few hot sets with tags from a small pool, so lines stay live and evictions have choices.
  task automatic random_item(int hot_base);
    int          pick;
    logic [1:0]  func;
    logic [5:0]  set_index;
    logic [31:0] tag;
    pick = $urandom_range(0, 99);
    if (pick < 45)      func = lvs_pkg::FUNC_ACCESS;
    else if (pick < 75) func = lvs_pkg::FUNC_UPDATE;
    else if (pick < 95) func = lvs_pkg::FUNC_EVICT;
    else                func = FUNC_SPARE;
    set_index = ($urandom_range(0, 4) != 0) ? 6'(hot_base + $urandom_range(0, 3))
                                            : 6'($urandom_range(0, 63));
    tag = ($urandom_range(0, 4) != 0) ? tag_pool[$urandom_range(0, 7)] : $urandom;
    send_item(func, set_index, tag, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
  endtask

  initial begin : stimulus
    int hot_base;
    rst                = 1'b1;
    req_if.valid       = 1'b0;
    req_if.func        = lvs_pkg::FUNC_ACCESS;
    req_if.set_index   = '0;
    req_if.tag         = '0;
    req_if.way         = '0;
    req_if.dirty       = 1'b0;
    cfg_if.valid       = 1'b0;
    cfg_if.policy_mode = 1'b0;
    burst_left         = $urandom_range(1, 30);
    tag_pool[0]        = 32'h0000_0000;
    tag_pool[1]        = 32'hFFFF_FFFF;
    for (int i = 2; i < 8; i++) tag_pool[i] = $urandom;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    write_policy(1'b0);
    // reset lines all hold tag 0: the highest way takes the hit
    send_item(lvs_pkg::FUNC_ACCESS, 6'd0, 32'h0000_0000, 3'd0, 1'b0);
    send_item(lvs_pkg::FUNC_ACCESS, 6'd63, 32'hFFFF_FFFF, 3'd7, 1'b1);
    send_item(lvs_pkg::FUNC_EVICT, 6'd1, 32'h0000_0000, 3'd0, 1'b0);
    send_item(lvs_pkg::FUNC_UPDATE, 6'd0, 32'h0000_00A5, 3'd0, 1'b1);
    send_item(lvs_pkg::FUNC_UPDATE, 6'd0, 32'h0000_005A, 3'd1, 1'b0);
    send_item(lvs_pkg::FUNC_UPDATE, 6'd0, 32'h0000_00A5, 3'd2, 1'b0);
    send_item(lvs_pkg::FUNC_ACCESS, 6'd0, 32'h0000_00A5, 3'd0, 1'b0);
    send_item(lvs_pkg::FUNC_ACCESS, 6'd0, 32'h0000_005A, 3'd0, 1'b0);
    send_item(lvs_pkg::FUNC_ACCESS, 6'd0, 32'h0000_0000, 3'd0, 1'b0);
    repeat (4) send_item(lvs_pkg::FUNC_EVICT, 6'd0, 32'h0000_0000, 3'd0, 1'b0);
    send_item(FUNC_SPARE, 6'd63, 32'hFFFF_FFFF, 3'd7, 1'b1);
    send_item(lvs_pkg::FUNC_UPDATE, 6'd63, 32'hFFFF_FFFF, 3'd7, 1'b1);
    send_item(lvs_pkg::FUNC_ACCESS, 6'd63, 32'hFFFF_FFFF, 3'd0, 1'b0);
    send_item(lvs_pkg::FUNC_EVICT, 6'd63, 32'hFFFF_FFFF, 3'd7, 1'b1);

    write_policy(1'b1);
    send_item(lvs_pkg::FUNC_UPDATE, 6'd2, 32'h0000_0011, 3'd0, 1'b1);
    send_item(lvs_pkg::FUNC_UPDATE, 6'd2, 32'h0000_0022, 3'd3, 1'b0);
    send_item(lvs_pkg::FUNC_UPDATE, 6'd2, 32'h0000_0033, 3'd7, 1'b1);
    send_item(lvs_pkg::FUNC_ACCESS, 6'd2, 32'h0000_0011, 3'd0, 1'b0);
    send_item(lvs_pkg::FUNC_ACCESS, 6'd2, 32'h0000_0022, 3'd0, 1'b0);
    send_item(lvs_pkg::FUNC_ACCESS, 6'd2, 32'h0000_0033, 3'd0, 1'b0);
    send_item(lvs_pkg::FUNC_ACCESS, 6'd2, 32'h0000_0011, 3'd0, 1'b0);
    // clean way first, then dirty ways oldest first, then an empty set
    repeat (4) send_item(lvs_pkg::FUNC_EVICT, 6'd2, 32'h0000_0000, 3'd0, 1'b0);

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      write_policy(phase[0]);
      hot_base = $urandom_range(0, 60);
      repeat (PHASE_ITEMS) random_item(hot_base);
    end

    wait_for_results();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
